/* design/rsls_pkg.sv */
// ============================================================================
// rsls_pkg
// Shared types and constants for the range signal light sequencer.
// ============================================================================
`default_nettype none

package rsls_pkg;

    // Width of the millisecond-scaled compare path (covers up to 1000 ticks/s)
    localparam int CMP_W = 30;

    // Width of a configuration register (milliseconds)
    localparam int CFG_W = 20;

    // Scaled elapsed counter: holds (elapsed_ticks + 1) * 1000
    localparam logic [CMP_W-1:0] MS_STEP    = 30'd1000;
    localparam logic [CMP_W-1:0] SCALED_SAT = 30'd1048576000;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_CALL_MS   = 2'd0,
        CFG_SHOOT_MS  = 2'd1,
        CFG_EXPIRE_MS = 2'd2
    } cfg_idx_t;

    // Sequencer phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_CALL   = 4'b0010,
        PH_SHOOT  = 4'b0100,
        PH_EXPIRE = 4'b1000
    } phase_t;

    // Phase codes as reported on the result stream
    localparam logic [1:0] PCODE_IDLE   = 2'd0;
    localparam logic [1:0] PCODE_CALL   = 2'd1;
    localparam logic [1:0] PCODE_SHOOT  = 2'd2;
    localparam logic [1:0] PCODE_EXPIRE = 2'd3;

    // Beep requests
    localparam logic [1:0] BEEP_NONE  = 2'd0;
    localparam logic [1:0] BEEP_SHORT = 2'd1;
    localparam logic [1:0] BEEP_LONG  = 2'd2;

    // Whistle blast counts
    localparam logic [1:0] WHISTLE_NONE  = 2'd0;
    localparam logic [1:0] WHISTLE_SHOOT = 2'd1;
    localparam logic [1:0] WHISTLE_CALL  = 2'd2;
    localparam logic [1:0] WHISTLE_STOP  = 2'd3;

    // Result item as packed into the master tdata
    typedef struct packed {
        logic [6:0] pad;
        logic [1:0] phase_now;
        logic [1:0] beep_request;
        logic [1:0] whistle_blasts;
        logic       orange_lamp;
        logic       green_lamp;
        logic       red_lamp;
    } result_t;

endpackage

`default_nettype wire

/* design/range_signal_light_sequencer.sv */
// ============================================================================
// range_signal_light_sequencer
// Range signal light sequencer driven by one millisecond tick per item.
// ============================================================================
//
// Usage:
//   s_* channel: one item per timer tick, s_tdata[0] = start key,
//   s_tdata[1] = stop key. m_* channel: one result per tick with lamps,
//   whistle blast count, beep request and the current phase.
//   cfg_* port: phase lengths in milliseconds, written while idle; the
//   write also scales the length by TICKS_PER_SECOND, so the next tick may
//   follow in the very next cycle.
//   The result of an item is registered, on m_tdata in the cycle after
//   it is accepted. Throughput: one item per cycle while m_tready is
//   high; the single output register refills in the cycle it drains.
//   Stall: while m_tvalid is high and m_tready is low, the result is held
//   and s_tready is low, so no tick is lost.
//   Reset: phase idle (red lit), counters cleared, phase lengths back to
//   10 s call, 120 s shooting and 30 s expiring; no result is pending.
//   Timeouts are compared in a millisecond-scaled domain, (ticks+1)*1000
//   against length*TICKS_PER_SECOND, so no divider is needed.
//
`default_nettype none

module range_signal_light_sequencer #(
    parameter int TICKS_PER_SECOND = 1000,
    parameter int WARN_WINDOW_MS   = 5000
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // slave stream: [0] start_key, [1] stop_key
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [7:0]                 s_tdata,
    // master stream: [0] red_lamp, [1] green_lamp, [2] orange_lamp,
    // [4:3] whistle_blasts, [6:5] beep_request, [8:7] phase_now
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [15:0]                     m_tdata,
    // configuration write port
    input  wire logic                       cfg_wen,
    input  wire logic [1:0]                 cfg_idx,
    input  wire logic [rsls_pkg::CFG_W-1:0] cfg_wdata
);

    import rsls_pkg::*;

    localparam int MSEC_W = $clog2(TICKS_PER_SECOND);
    localparam logic [MSEC_W-1:0] MSEC_LAST = MSEC_W'(TICKS_PER_SECOND - 1);
    localparam logic [CFG_W-1:0]  WARN_MS   = CFG_W'(WARN_WINDOW_MS);
    localparam int WARN_RST_MS = (30000 >= WARN_WINDOW_MS) ? 30000 - WARN_WINDOW_MS : 0;
    localparam logic [CMP_W-1:0] CALL_RST   = CMP_W'(10000 * TICKS_PER_SECOND);
    localparam logic [CMP_W-1:0] SHOOT_RST  = CMP_W'(120000 * TICKS_PER_SECOND);
    localparam logic [CMP_W-1:0] EXPIRE_RST = CMP_W'(30000 * TICKS_PER_SECOND);
    localparam logic [CMP_W-1:0] WARN_RST   = CMP_W'(WARN_RST_MS * TICKS_PER_SECOND);

    // Phase lengths scaled by ticks per second
    logic [CMP_W-1:0] call_prod_reg;
    logic [CMP_W-1:0] shoot_prod_reg;
    logic [CMP_W-1:0] expire_prod_reg;
    logic [CMP_W-1:0] warn_prod_reg;
    logic [CFG_W-1:0] warn_ms;

    // Sequencer state
    phase_t           phase_reg, phase_next;
    logic [CMP_W-1:0] scaled_reg, scaled_next, scaled_inc;
    logic [MSEC_W-1:0] msec_reg, msec_next, msec_inc;
    logic [1:0]       whistle;
    logic [1:0]       beep;

    // Output register
    logic             out_valid_reg;
    result_t          out_data_reg;
    result_t          result;
    logic             in_fire;
    logic             start_key;
    logic             stop_key;

    assign start_key = s_tdata[0];
    assign stop_key  = s_tdata[1];
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_fire   = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Saturated warning window start in milliseconds
    assign warn_ms = (cfg_wdata >= WARN_MS) ? cfg_wdata - WARN_MS : '0;

    // Scale configuration writes into the compare domain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            call_prod_reg   <= CALL_RST;
            shoot_prod_reg  <= SHOOT_RST;
            expire_prod_reg <= EXPIRE_RST;
            warn_prod_reg   <= WARN_RST;
        end
        else if (cfg_wen)
        begin
            case (cfg_idx)
                CFG_CALL_MS:
                begin
                    call_prod_reg <= CMP_W'(cfg_wdata) * CMP_W'(TICKS_PER_SECOND);
                end
                CFG_SHOOT_MS:
                begin
                    shoot_prod_reg <= CMP_W'(cfg_wdata) * CMP_W'(TICKS_PER_SECOND);
                end
                CFG_EXPIRE_MS:
                begin
                    expire_prod_reg <= CMP_W'(cfg_wdata) * CMP_W'(TICKS_PER_SECOND);
                    warn_prod_reg   <= CMP_W'(warn_ms) * CMP_W'(TICKS_PER_SECOND);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Advance counters and phase for one tick
    always_comb
    begin
        scaled_inc  = (scaled_reg == SCALED_SAT) ? scaled_reg : scaled_reg + MS_STEP;
        msec_inc    = (msec_reg == MSEC_LAST) ? '0 : msec_reg + 1'b1;
        phase_next  = phase_reg;
        scaled_next = scaled_inc;
        msec_next   = msec_inc;
        whistle     = WHISTLE_NONE;
        beep        = BEEP_NONE;
        case (phase_reg)
            PH_IDLE:
            begin
                scaled_next = scaled_reg;
                msec_next   = msec_reg;
                if (start_key)
                begin
                    phase_next  = PH_CALL;
                    scaled_next = MS_STEP;
                    msec_next   = '0;
                    whistle     = WHISTLE_CALL;
                    beep        = (call_prod_reg >= MS_STEP) ? BEEP_SHORT : BEEP_NONE;
                end
            end
            PH_CALL:
            begin
                if (stop_key)
                begin
                    phase_next  = PH_IDLE;
                    scaled_next = MS_STEP;
                    msec_next   = '0;
                    beep        = BEEP_LONG;
                end
                else if (start_key || (scaled_inc > call_prod_reg))
                begin
                    phase_next  = PH_SHOOT;
                    scaled_next = MS_STEP;
                    msec_next   = '0;
                    whistle     = WHISTLE_SHOOT;
                end
                else if (msec_inc == '0)
                begin
                    beep = BEEP_SHORT;
                end
            end
            PH_SHOOT:
            begin
                if (stop_key)
                begin
                    phase_next  = PH_IDLE;
                    scaled_next = MS_STEP;
                    msec_next   = '0;
                    whistle     = WHISTLE_STOP;
                    beep        = BEEP_LONG;
                end
                else if (start_key)
                begin
                    phase_next  = PH_CALL;
                    scaled_next = MS_STEP;
                    msec_next   = '0;
                    whistle     = WHISTLE_CALL;
                    beep        = (call_prod_reg >= MS_STEP) ? BEEP_SHORT : BEEP_NONE;
                end
                else if (scaled_inc > shoot_prod_reg)
                begin
                    phase_next  = PH_EXPIRE;
                    scaled_next = MS_STEP;
                    msec_next   = '0;
                    beep        = ((MS_STEP > warn_prod_reg) &&
                                   (MS_STEP <= expire_prod_reg)) ? BEEP_SHORT : BEEP_NONE;
                end
            end
            PH_EXPIRE:
            begin
                if (stop_key || (scaled_inc > expire_prod_reg))
                begin
                    phase_next  = PH_IDLE;
                    scaled_next = MS_STEP;
                    msec_next   = '0;
                    whistle     = WHISTLE_STOP;
                    beep        = BEEP_LONG;
                end
                else if (start_key)
                begin
                    phase_next  = PH_CALL;
                    scaled_next = MS_STEP;
                    msec_next   = '0;
                    whistle     = WHISTLE_CALL;
                    beep        = (call_prod_reg >= MS_STEP) ? BEEP_SHORT : BEEP_NONE;
                end
                else if ((msec_inc == '0) && (scaled_inc > warn_prod_reg) &&
                         (scaled_inc <= expire_prod_reg))
                begin
                    beep = BEEP_SHORT;
                end
            end
            default:
            begin
                phase_next  = PH_IDLE;
                scaled_next = MS_STEP;
                msec_next   = '0;
            end
        endcase
    end

    // Assemble the result item from the next phase
    always_comb
    begin
        result                = '0;
        result.whistle_blasts = whistle;
        result.beep_request   = beep;
        case (phase_next)
            PH_IDLE:
            begin
                result.red_lamp  = 1'b1;
                result.phase_now = PCODE_IDLE;
            end
            PH_CALL:
            begin
                result.red_lamp  = 1'b1;
                result.phase_now = PCODE_CALL;
            end
            PH_SHOOT:
            begin
                result.green_lamp = 1'b1;
                result.phase_now  = PCODE_SHOOT;
            end
            PH_EXPIRE:
            begin
                result.orange_lamp = 1'b1;
                result.phase_now   = PCODE_EXPIRE;
            end
            default:
            begin
                result.red_lamp  = 1'b1;
                result.phase_now = PCODE_IDLE;
            end
        endcase
    end

    // Update state on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            scaled_reg <= MS_STEP;
            msec_reg   <= '0;
        end
        else if (in_fire)
        begin
            phase_reg  <= phase_next;
            scaled_reg <= scaled_next;
            msec_reg   <= msec_next;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            out_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= result;
        end
    end

    // Checks
    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> m_tvalid)
        else $error("accepted tick produced no result");

    a_msec_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        msec_reg <= MSEC_LAST)
        else $error("position within second out of range");

    a_long_beep_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[6:5] == BEEP_LONG)) |-> (m_tdata[8:7] == PCODE_IDLE))
        else $error("long beep outside of stop");

    a_call_whistle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[4:3] == WHISTLE_CALL)) |-> (m_tdata[8:7] == PCODE_CALL))
        else $error("call whistle without call phase");

    a_one_lamp: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot(m_tdata[2:0]))
        else $error("lamp pattern not one-hot");

endmodule

`default_nettype wire

/* bench/tb_range_signal_light_sequencer.sv */
// ----------------------------------------------------------------------------
// tb_range_signal_light_sequencer
// Self-checking bench for the range signal light sequencer. A queue of key
// ticks feeds a stream driver; every accepted tick runs through a local
// phase predictor, and a monitor compares each result item field by field
// against the oldest predicted one. Phase lengths are reprogrammed between
// runs, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_range_signal_light_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import rsls_pkg::*;

    localparam int TICKS_PER_SECOND = 1000;
    localparam int WARN_WINDOW_MS   = 5000;
    localparam logic [19:0] ELAPSED_MAX = 20'hFFFFF;

    // Pacing of the two stream sides, switched every hundred items
    typedef enum int {
        PACE_FREE     = 0,
        PACE_SENDER   = 1,
        PACE_RECEIVER = 2,
        PACE_BOTH     = 3
    } pace_t;

    // One tick of keys, start in the low bit
    typedef struct packed {
        logic stop;
        logic start;
    } keys_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;
    logic                 cfg_wen = 1'b0;
    cfg_idx_t             cfg_idx = CFG_CALL_MS;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    keys_t                pending_ticks[$];
    result_t              expected_results[$];
    int                   ticks_sent = 0;
    int                   failures = 0;
    int                   hold_left = 0;
    bit                   hold_done = 1'b0;

    // Predictor copy of the phase lengths and sequencer state
    logic [19:0]          len_call;
    logic [19:0]          len_shoot;
    logic [19:0]          len_expire;
    logic [1:0]           seq_phase;
    logic [19:0]          seq_elapsed;
    logic [9:0]           seq_sec_pos;

    range_signal_light_sequencer #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .WARN_WINDOW_MS   (WARN_WINDOW_MS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [0] start_key, [1] stop_key
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [0] red, [1] green, [2] orange, [4:3] whistle,
                                // [6:5] beep, [8:7] phase_now
        .cfg_wen   (cfg_wen),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    // Convert milliseconds to ticks
    function automatic logic [63:0] ms_ticks(input logic [19:0] ms);
        return (64'(ms) * TICKS_PER_SECOND) / 1000;
    endfunction

    // Short beep on whole seconds inside the warning window of time expiring
    function automatic logic [1:0] warning_beep();
        logic [19:0] win_start;
        win_start = (len_expire >= WARN_WINDOW_MS) ? 20'(len_expire - WARN_WINDOW_MS) : 20'd0;
        if (seq_sec_pos == 0 && 64'(seq_elapsed) >= ms_ticks(win_start)
                && 64'(seq_elapsed) < ms_ticks(len_expire))
            return BEEP_SHORT;
        return BEEP_NONE;
    endfunction

    // Switch phase, clear counters, return {whistle, beep} of the entry
    function automatic logic [3:0] enter_phase(input logic [1:0] next);
        logic [1:0] blasts;
        logic [1:0] beep;
        seq_phase   = next;
        seq_elapsed = '0;
        seq_sec_pos = '0;
        blasts      = WHISTLE_NONE;
        beep        = BEEP_NONE;
        case (next)
            PCODE_CALL:
            begin
                blasts = WHISTLE_CALL;
                beep   = (ms_ticks(len_call) > 0) ? BEEP_SHORT : BEEP_NONE;
            end
            PCODE_SHOOT:  blasts = WHISTLE_SHOOT;
            PCODE_EXPIRE: beep = warning_beep();
            default:      beep = BEEP_LONG;
        endcase
        return {blasts, beep};
    endfunction

    // Advance the sequencer by one tick and form the lamp/sound item
    function automatic result_t advance_tick(input logic start, input logic stop);
        logic [3:0] sound;
        result_t    res;
        sound = {WHISTLE_NONE, BEEP_NONE};
        if (seq_phase == PCODE_IDLE)
        begin
            if (start)
                sound = enter_phase(PCODE_CALL);
        end
        else
        begin
            if (seq_elapsed != ELAPSED_MAX)
                seq_elapsed = seq_elapsed + 20'd1;
            seq_sec_pos = (int'(seq_sec_pos) + 1 >= TICKS_PER_SECOND) ? 10'd0 : seq_sec_pos + 10'd1;
            case (seq_phase)
                PCODE_CALL:
                begin
                    if (stop)
                        sound = enter_phase(PCODE_IDLE);
                    else if (start || 64'(seq_elapsed) >= ms_ticks(len_call))
                        sound = enter_phase(PCODE_SHOOT);
                    else if (seq_sec_pos == 0)
                        sound[1:0] = BEEP_SHORT;
                end
                PCODE_SHOOT:
                begin
                    if (stop)
                    begin
                        sound = enter_phase(PCODE_IDLE);
                        sound[3:2] = WHISTLE_STOP;
                    end
                    else if (start)
                        sound = enter_phase(PCODE_CALL);
                    else if (64'(seq_elapsed) >= ms_ticks(len_shoot))
                        sound = enter_phase(PCODE_EXPIRE);
                end
                default:
                begin
                    if (stop || 64'(seq_elapsed) >= ms_ticks(len_expire))
                    begin
                        sound = enter_phase(PCODE_IDLE);
                        sound[3:2] = WHISTLE_STOP;
                    end
                    else if (start)
                        sound = enter_phase(PCODE_CALL);
                    else
                        sound[1:0] = warning_beep();
                end
            endcase
        end
        res                = '0;
        res.red_lamp       = (seq_phase == PCODE_IDLE || seq_phase == PCODE_CALL);
        res.green_lamp     = (seq_phase == PCODE_SHOOT);
        res.orange_lamp    = (seq_phase == PCODE_EXPIRE);
        res.whistle_blasts = sound[3:2];
        res.beep_request   = sound[1:0];
        res.phase_now      = seq_phase;
        return res;
    endfunction

    function automatic pace_t pace_now();
        return pace_t'((ticks_sent / 100) % 4);
    endfunction

    function automatic bit sender_pause();
        case (pace_now())
            PACE_SENDER: return $urandom_range(0, 99) < 70;
            PACE_BOTH:   return $urandom_range(0, 99) < 29;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_pause();
        case (pace_now())
            PACE_RECEIVER: return $urandom_range(0, 99) < 70;
            PACE_BOTH:     return $urandom_range(0, 99) < 29;
            default:       return 1'b0;
        endcase
    endfunction

    task automatic field_error(input string name, input logic [6:0] want, input logic [6:0] got);
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        failures++;
    endtask

    // Compare one result item with the oldest prediction
    task automatic check_result(input logic [15:0] raw);
        result_t got;
        result_t want;
        got = result_t'(raw);
        if (expected_results.size() == 0)
        begin
            $display("%0t: result %h with none expected, got %h", $time, raw, raw);
            failures++;
        end
        else
        begin
            want = expected_results.pop_front();
            if (got.red_lamp !== want.red_lamp)
                field_error("red_lamp", 7'(want.red_lamp), 7'(got.red_lamp));
            if (got.green_lamp !== want.green_lamp)
                field_error("green_lamp", 7'(want.green_lamp), 7'(got.green_lamp));
            if (got.orange_lamp !== want.orange_lamp)
                field_error("orange_lamp", 7'(want.orange_lamp), 7'(got.orange_lamp));
            if (got.whistle_blasts !== want.whistle_blasts)
                field_error("whistle_blasts", 7'(want.whistle_blasts),
                            7'(got.whistle_blasts));
            if (got.beep_request !== want.beep_request)
                field_error("beep_request", 7'(want.beep_request), 7'(got.beep_request));
            if (got.phase_now !== want.phase_now)
                field_error("phase_now", 7'(want.phase_now), 7'(got.phase_now));
            if (got.pad !== want.pad)
                field_error("pad", want.pad, got.pad);
        end
    endtask

    // Driver: offer queued ticks, predict each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(advance_tick(s_tdata[0], s_tdata[1]));
                ticks_sent <= ticks_sent + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_ticks.size() != 0 && !sender_pause())
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {6'b0, pending_ticks.pop_front()};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off once, so the block backs up its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && ticks_sent >= 200)
        begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: check accepted results, drive ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            m_tready <= (hold_left == 0) && !receiver_pause();
        end
    end

    task automatic push_tick(input logic start, input logic stop);
        pending_ticks.push_back('{stop: stop, start: start});
    endtask

    task automatic queue_random_ticks(input int count, input int start_pct, input int stop_pct);
        for (int i = 0; i < count; i++)
            push_tick($urandom_range(0, 99) < start_pct, $urandom_range(0, 99) < stop_pct);
    endtask

    // Hold until every queued tick is taken and every result is back
    task automatic wait_drained();
        while (pending_ticks.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Write all three phase lengths, one register per cycle
    task automatic program_lengths(input logic [19:0] call_ms, input logic [19:0] shoot_ms,
                                   input logic [19:0] expire_ms);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_idx   <= CFG_CALL_MS;
        cfg_wdata <= call_ms;
        @(posedge clk);
        cfg_idx   <= CFG_SHOOT_MS;
        cfg_wdata <= shoot_ms;
        @(posedge clk);
        cfg_idx   <= CFG_EXPIRE_MS;
        cfg_wdata <= expire_ms;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        len_call   = call_ms;
        len_shoot  = shoot_ms;
        len_expire = expire_ms;
    endtask

    // Stimulus
    initial
    begin
        len_call    = 20'd10000;
        len_shoot   = 20'd120000;
        len_expire  = 20'd30000;
        seq_phase   = PCODE_IDLE;
        seq_elapsed = '0;
        seq_sec_pos = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Key handling with the reset lengths
        push_tick(1'b0, 1'b1);      // stop ignored while idle
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b1);      // both keys while idle: start wins
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b1);      // stop beats start in call to line
        push_tick(1'b1, 1'b0);
        push_tick(1'b1, 1'b0);      // start skips ahead to shooting
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b0);      // start in shooting returns to call
        push_tick(1'b1, 1'b0);
        push_tick(1'b1, 1'b1);      // stop from shooting: three blasts
        wait_drained();

        // Zero- and one-millisecond phases: every timeout fires on the first tick
        program_lengths(20'd0, 20'd1, 20'd0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b0);      // timeout beats start in time expiring
        wait_drained();

        // Short phases: saturated warning window, start and stop in expiring
        program_lengths(20'd3, 20'd2, 20'd4);
        push_tick(1'b1, 1'b0);
        repeat (5) push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b0);      // start in time expiring returns to call
        repeat (6) push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b1);      // stop in time expiring
        wait_drained();

        // Warning window opening at zero: short beep on entry to time expiring
        program_lengths(20'd6, 20'd3, 20'd4999);
        push_tick(1'b1, 1'b0);
        repeat (20) push_tick(1'b0, 1'b0);
        wait_drained();

        // Largest lengths with random keys
        program_lengths(20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        push_tick(1'b1, 1'b0);
        queue_random_ticks(100, 10, 6);
        wait_drained();

        // Random short lengths, mostly plain ticks so phases run out
        for (int g = 0; g < 5; g++)
        begin
            program_lengths(20'($urandom_range(0, 12)), 20'($urandom_range(0, 12)),
                            20'($urandom_range(0, 12)));
            push_tick(1'b1, 1'b0);
            queue_random_ticks(70, 6, 4);
            queue_random_ticks(10, 50, 50);
            wait_drained();
        end

        repeat (4) @(posedge clk);
        if (failures == 0)
            $display("range_signal_light_sequencer: match");
        else
            $display("range_signal_light_sequencer: mismatch");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4000000;
        $display("range_signal_light_sequencer: mismatch");
        $finish;
    end

endmodule

/* range_signal_light_sequencer.f */
design/rsls_pkg.sv
design/range_signal_light_sequencer.sv
bench/tb_range_signal_light_sequencer.sv
